[src/pfpw_pkg.sv]
// Shared types and constants for the page framebuffer pixel writer.
package pfpw_pkg;

   // Bus byte constants
   localparam logic [7:0] SLAVE_ADDR_RESET = 8'h78;
   localparam logic [7:0] CTRL_COMMAND     = 8'h00;
   localparam logic [7:0] CTRL_DATA        = 8'h40;
   localparam logic [7:0] CMD_PAGE_BASE    = 8'hB0;
   localparam logic [7:0] CMD_COL_HIGH     = 8'h10;
   localparam logic [7:0] BYTE_ZERO        = 8'h00;

   // Register word indexes on the configuration port
   typedef enum logic {
      CSR_SLAVE_ADDR = 1'b0
   } csr_index_type;

   // Input transfer payload
   typedef struct packed {
      logic [6:0] pixel_column;
      logic [5:0] pixel_row;
      logic       set_pixel;
   } req_payload_type;

   // Result transfer payload
   typedef struct packed {
      logic [7:0] bus_byte;
      logic       frame_start;
      logic       frame_end;
      logic       last;
   } rsp_payload_type;

   // Update request from the sequencer to the frame store
   typedef struct packed {
      logic       start;
      logic [6:0] column;
      logic [2:0] page;
      logic [2:0] bit_sel;
      logic       set_pixel;
   } upd_req_type;

   // Status from the frame store back to the sequencer
   typedef struct packed {
      logic       ready;
      logic [7:0] data;
   } store_stat_type;

endpackage

[src/pfpw_frame_store.sv]
// Page-organized frame memory with clearing pass and read-modify-write of one byte.
module pfpw_frame_store #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pfpw_pkg::upd_req_type    upd,
   output pfpw_pkg::store_stat_type stat
);

   localparam int DEPTH = COLUMNS * PAGES;
   localparam int AW    = $clog2(DEPTH);

   logic [7:0]    mem [DEPTH];

   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          clr_busy_ff, clr_busy_in;

   logic [AW-1:0] upd_addr_ff;
   logic [7:0]    mask_ff;
   logic          set_ff;
   logic          in_range_ff;
   logic          stage_ff, stage_in;
   logic [7:0]    rd_data_ff;
   logic [7:0]    data_ff;

   logic [AW-1:0] rd_addr;
   logic          in_range;
   logic [7:0]    new_byte;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   // Locate the byte for the requested column and page
   always_comb begin
      rd_addr  = AW'(AW'(upd.column) * AW'(PAGES)) + AW'(upd.page);
      in_range = (int'(upd.column) < COLUMNS) && (int'(upd.page) < PAGES);
   end

   // Modify the fetched byte
   always_comb begin
      if (set_ff) begin
         new_byte = rd_data_ff | mask_ff;
      end else begin
         new_byte = rd_data_ff & ~mask_ff;
      end
   end

   // Step the clearing pass through the entries in order after reset, stopping after the last one
   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
   end

   // Select the single write port between clearing and update
   always_comb begin
      if (clr_busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = pfpw_pkg::BYTE_ZERO;
      end else begin
         wr_en   = stage_ff && in_range_ff;
         wr_addr = upd_addr_ff;
         wr_data = new_byte;
      end
   end

   assign stage_in = upd.start;

   // Memory array: one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
         stage_ff    <= 1'b0;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
         stage_ff    <= stage_in;
      end
   end

   // Hold the request and the updated byte
   always_ff @(posedge clock) begin
      if (upd.start) begin
         upd_addr_ff <= rd_addr;
         mask_ff     <= 8'(1) << upd.bit_sel;
         set_ff      <= upd.set_pixel;
         in_range_ff <= in_range;
      end
      if (stage_ff) begin
         data_ff <= in_range_ff ? new_byte : pfpw_pkg::BYTE_ZERO;
      end
   end

   assign stat.ready = !clr_busy_ff;
   assign stat.data  = data_ff;

endmodule

[src/page_framebuffer_pixel_writer.sv]
// Top level of the page framebuffer pixel writer: request sequencer and bus byte emitter.
// The first bus byte is registered in the cycle after the request transfer; twelve bytes in all.
// A new request is taken only once the last one's bytes are sent; one byte per cycle unless rsp_stall holds.
// Reset: synchronous; a clearing pass zeroes all COLUMNS * PAGES memory entries
// (1024 by default), during which requests stall; configuration writes are taken throughout.
module page_framebuffer_pixel_writer #(
   parameter int COLUMNS = 128,
   parameter int PAGES   = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  pfpw_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output pfpw_pkg::rsp_payload_type rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      POS_ADDR,
      POS_CTRL,
      POS_PAYLOAD
   } pos_type;

   typedef enum logic [1:0] {
      TXN_PAGE,
      TXN_COL_HIGH,
      TXN_COL_LOW,
      TXN_DATA
   } txn_type;

   state_type                 state_ff;
   pos_type                   pos_ff;
   txn_type                   txn_ff;
   logic [6:0]                col_ff;
   logic [2:0]                page_ff;
   logic                      rsp_valid_ff;
   pfpw_pkg::rsp_payload_type rsp_payload_ff;
   logic [7:0]                slave_addr_ff;

   pfpw_pkg::upd_req_type     upd;
   pfpw_pkg::store_stat_type  stat;
   pfpw_pkg::rsp_payload_type next_byte;
   pos_type                   pos_next;
   txn_type                   txn_next;
   logic                      out_free;
   logic                      accept;
   logic                      csr_write;

   pfpw_frame_store #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .stat  (stat)
   );

   // Handshake on the request side
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && stat.ready && out_free);
   assign accept    = req_valid && !req_stall;

   // Launch the frame store update on every request transfer
   always_comb begin
      upd.start     = accept;
      upd.column    = req_payload.pixel_column;
      upd.page      = req_payload.pixel_row[5:3];
      upd.bit_sel   = req_payload.pixel_row[2:0];
      upd.set_pixel = req_payload.set_pixel;
   end

   // Build the bus byte for the current transaction and position
   always_comb begin
      next_byte.frame_start = (pos_ff == POS_ADDR);
      next_byte.frame_end   = (pos_ff == POS_PAYLOAD);
      next_byte.last        = (pos_ff == POS_PAYLOAD) && (txn_ff == TXN_DATA);
      case (pos_ff)
         POS_ADDR: begin
            next_byte.bus_byte = slave_addr_ff;
         end
         POS_CTRL: begin
            next_byte.bus_byte = (txn_ff == TXN_DATA) ? pfpw_pkg::CTRL_DATA
                                                      : pfpw_pkg::CTRL_COMMAND;
         end
         default: begin
            case (txn_ff)
               TXN_PAGE:     next_byte.bus_byte = pfpw_pkg::CMD_PAGE_BASE + {5'd0, page_ff};
               TXN_COL_HIGH: next_byte.bus_byte = pfpw_pkg::CMD_COL_HIGH | {5'd0, col_ff[6:4]};
               TXN_COL_LOW:  next_byte.bus_byte = {4'd0, col_ff[3:0]};
               default:      next_byte.bus_byte = stat.data;
            endcase
         end
      endcase
   end

   // Step through three bytes per transaction, four transactions per request
   always_comb begin
      pos_next = pos_ff;
      txn_next = txn_ff;
      case (pos_ff)
         POS_ADDR: pos_next = POS_CTRL;
         POS_CTRL: pos_next = POS_PAYLOAD;
         default: begin
            pos_next = POS_ADDR;
            case (txn_ff)
               TXN_PAGE:     txn_next = TXN_COL_HIGH;
               TXN_COL_HIGH: txn_next = TXN_COL_LOW;
               default:      txn_next = TXN_DATA;
            endcase
         end
      endcase
   end

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_ADDR;
         txn_ff       <= TXN_PAGE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // First byte of the page transaction goes out at once
                  rsp_valid_ff                <= 1'b1;
                  rsp_payload_ff.bus_byte     <= slave_addr_ff;
                  rsp_payload_ff.frame_start  <= 1'b1;
                  rsp_payload_ff.frame_end    <= 1'b0;
                  rsp_payload_ff.last         <= 1'b0;
                  pos_ff                      <= POS_CTRL;
                  txn_ff                      <= TXN_PAGE;
                  col_ff                      <= req_payload.pixel_column;
                  page_ff                     <= req_payload.pixel_row[5:3];
                  state_ff                    <= ST_EMIT;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_payload_ff <= next_byte;
                  pos_ff         <= pos_next;
                  txn_ff         <= txn_next;
                  if (next_byte.last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Configuration register write
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_addr_ff <= pfpw_pkg::SLAVE_ADDR_RESET;
      end else if (csr_write && (paddr[2] == pfpw_pkg::CSR_SLAVE_ADDR)) begin
         slave_addr_ff <= pwdata[7:0];
      end
   end

   // Configuration register read
   always_comb begin
      if (paddr[2] == pfpw_pkg::CSR_SLAVE_ADDR) begin
         prdata = {24'd0, slave_addr_ff};
      end else begin
         prdata = 32'd0;
      end
   end

   assign pready      = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
